// ===== src/vsrt_pkg.sv =====
// Shared types, constants and saturation helper for the vertex transform block.
`timescale 1ns / 1ps

package vsrt_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned ProdW    = CoordW + CoefW;
  localparam int unsigned SatW     = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned PipeDepth = 9;
  localparam int unsigned OccW     = 4;

  localparam logic [CfgDataW-1:0] ScaleReset = 48'h1000_1000_1000;
  localparam logic [31:0]         RotReset   = 32'h4000_0000;

  localparam logic signed [SatW-1:0] SatMax = 40'sh00_7FFF_FFFF;
  localparam logic signed [SatW-1:0] SatMin = 40'shFF_8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    RegScale  = 3'd0,
    RegRotX   = 3'd1,
    RegRotY   = 3'd2,
    RegRotZ   = 3'd3,
    RegTransX = 3'd4,
    RegTransY = 3'd5,
    RegTransZ = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     clip;
  } vec_t;

  typedef struct packed {
    logic signed [CoordW-1:0] val;
    logic                     clip;
  } sat_res_t;

  // Clamp a wide signed value to the 32-bit coordinate range.
  function automatic sat_res_t sat32(input logic signed [SatW-1:0] v);
    sat_res_t r;
    if (v > SatMax) begin
      r.val  = SatMax[CoordW-1:0];
      r.clip = 1'b1;
    end else if (v < SatMin) begin
      r.val  = SatMin[CoordW-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[CoordW-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== src/vsrt_if.sv =====
// Valid/ready channel interfaces for vertices in and transformed results out.
`timescale 1ns / 1ps

interface vsrt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;

  modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                  output ready);
endinterface

interface vsrt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               saturated;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input saturated, output ready);
endinterface

// ===== src/vertex_scale_rotate_translate.sv =====
// Top level of the vertex scale, rotate and translate pipeline.
`timescale 1ns / 1ps

// Takes one signed Q16.16 vertex per transaction and returns it scaled by
// three Q4.12 factors, rotated about x, then y, then z with software-loaded
// Q2.14 cos/sin pairs, and translated by Q16.16 offsets. Scaling and rotation
// round half up, every stage clamps to 32 bits; the saturated flag reports
// any clamp. The pipeline is nine register stages deep (two for scaling, two
// for each of the three rotations, one for the offset add, which is also the
// output register), and a new vertex is accepted every cycle while the output
// side keeps taking results. Backpressure stalls only the stages that hold
// data; empty stages keep filling. Configuration registers must be written
// only when the pipeline is empty; a write to index seven is dropped.

module vertex_scale_rotate_translate import vsrt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  vsrt_in_if.sink             vtx_i,
  vsrt_out_if.source          res_o
);

  // Configuration registers.
  logic [CfgDataW-1:0]      scale_q;
  logic [31:0]              rot_x_q, rot_y_q, rot_z_q;
  logic signed [CoordW-1:0] trans_x_q, trans_y_q, trans_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= ScaleReset;
      rot_x_q   <= RotReset;
      rot_y_q   <= RotReset;
      rot_z_q   <= RotReset;
      trans_x_q <= '0;
      trans_y_q <= '0;
      trans_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegScale:  scale_q   <= cfg_wdata_i;
        RegRotX:   rot_x_q   <= cfg_wdata_i[31:0];
        RegRotY:   rot_y_q   <= cfg_wdata_i[31:0];
        RegRotZ:   rot_z_q   <= cfg_wdata_i[31:0];
        RegTransX: trans_x_q <= $signed(cfg_wdata_i[31:0]);
        RegTransY: trans_y_q <= $signed(cfg_wdata_i[31:0]);
        RegTransZ: trans_z_q <= $signed(cfg_wdata_i[31:0]);
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Stage-to-stage handshakes and payloads.
  vec_t in_vec, sc_out, rx_in, rx_out, ry_in, ry_out, rz_in, rz_out, tr_in, tr_out;
  logic sc_vld, sc_rdy, rx_vld, rx_rdy, ry_vld, ry_rdy, rz_vld, rz_rdy;

  always_comb begin
    in_vec.x    = vtx_i.vertex_x;
    in_vec.y    = vtx_i.vertex_y;
    in_vec.z    = vtx_i.vertex_z;
    in_vec.clip = 1'b0;
  end

  vsrt_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vtx_i.valid),
    .in_ready_o  (vtx_i.ready),
    .in_data_i   (in_vec),
    .scale_i     (scale_q),
    .out_valid_o (sc_vld),
    .out_ready_i (sc_rdy),
    .out_data_o  (sc_out)
  );

  // Rotate about x: the rotator's plane is (y, z).
  always_comb begin
    rx_in.x    = sc_out.y;
    rx_in.y    = sc_out.z;
    rx_in.z    = sc_out.x;
    rx_in.clip = sc_out.clip;
  end

  vsrt_rotate u_rot_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sc_vld),
    .in_ready_o  (sc_rdy),
    .in_data_i   (rx_in),
    .coeffs_i    (rot_x_q),
    .out_valid_o (rx_vld),
    .out_ready_i (rx_rdy),
    .out_data_o  (rx_out)
  );

  // Rotate about y: plane is (z, x), which gives z' = c*z - s*x, x' = c*x + s*z.
  always_comb begin
    ry_in.x    = rx_out.y;  // z
    ry_in.y    = rx_out.z;  // x
    ry_in.z    = rx_out.x;  // y
    ry_in.clip = rx_out.clip;
  end

  vsrt_rotate u_rot_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_vld),
    .in_ready_o  (rx_rdy),
    .in_data_i   (ry_in),
    .coeffs_i    (rot_y_q),
    .out_valid_o (ry_vld),
    .out_ready_i (ry_rdy),
    .out_data_o  (ry_out)
  );

  // Rotate about z: plane is (x, y); restore natural order first.
  always_comb begin
    rz_in.x    = ry_out.y;
    rz_in.y    = ry_out.z;
    rz_in.z    = ry_out.x;
    rz_in.clip = ry_out.clip;
  end

  vsrt_rotate u_rot_z (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ry_vld),
    .in_ready_o  (ry_rdy),
    .in_data_i   (rz_in),
    .coeffs_i    (rot_z_q),
    .out_valid_o (rz_vld),
    .out_ready_i (rz_rdy),
    .out_data_o  (rz_out)
  );

  assign tr_in = rz_out;

  vsrt_translate u_translate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rz_vld),
    .in_ready_o  (rz_rdy),
    .in_data_i   (tr_in),
    .tx_i        (trans_x_q),
    .ty_i        (trans_y_q),
    .tz_i        (trans_z_q),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (tr_out)
  );

  assign res_o.out_x     = tr_out.x;
  assign res_o.out_y     = tr_out.y;
  assign res_o.out_z     = tr_out.z;
  assign res_o.saturated = tr_out.clip;

  // Count transactions in flight for the checks below.
  logic            in_fire, out_fire;
  logic [OccW-1:0] occ_q;

  assign in_fire  = vtx_i.valid && vtx_i.ready;
  assign out_fire = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (in_fire && !out_fire) begin
      occ_q <= occ_q + OccW'(1);
    end else if (out_fire && !in_fire) begin
      occ_q <= occ_q - OccW'(1);
    end
  end

  // Never more vertices in flight than pipeline stages.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(PipeDepth))
    else $error("more transactions in flight than pipeline stages");

  // A result only appears for a vertex that was accepted and not yet delivered.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> occ_q != '0)
    else $error("result presented with empty pipeline");

  // Without backpressure the pipeline never refuses a vertex.
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.ready |-> vtx_i.ready)
    else $error("input stalled while output side is ready");

endmodule

// ===== src/vsrt_scale.sv =====
// Per-axis Q4.12 scaling: multiply stage, then round and saturate stage.
`timescale 1ns / 1ps

module vsrt_scale import vsrt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vec_t                in_data_i,
  input  logic [CfgDataW-1:0] scale_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vec_t                out_data_o
);

  logic a_vld_q, b_vld_q;
  logic a_rdy, b_rdy;
  logic signed [ProdW-1:0] px_q, py_q, pz_q;
  logic clip_a_q;
  vec_t b_d, b_q;
  sat_res_t sx, sy, sz;
  logic signed [ProdW:0] rx, ry, rz;

  assign b_rdy      = !b_vld_q || out_ready_i;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= in_valid_i;
      if (b_rdy) b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      px_q     <= in_data_i.x * $signed(scale_i[47:32]);
      py_q     <= in_data_i.y * $signed(scale_i[31:16]);
      pz_q     <= in_data_i.z * $signed(scale_i[15:0]);
      clip_a_q <= in_data_i.clip;
    end
    if (b_rdy && a_vld_q) begin
      b_q <= b_d;
    end
  end

  // Add half an LSB of Q16.16, then floor by 12 bits.
  always_comb begin
    rx = $signed({px_q[ProdW-1], px_q} + (ProdW+1)'(2048)) >>> 12;
    ry = $signed({py_q[ProdW-1], py_q} + (ProdW+1)'(2048)) >>> 12;
    rz = $signed({pz_q[ProdW-1], pz_q} + (ProdW+1)'(2048)) >>> 12;
    sx = sat32(rx[SatW-1:0]);
    sy = sat32(ry[SatW-1:0]);
    sz = sat32(rz[SatW-1:0]);
    b_d.x    = sx.val;
    b_d.y    = sy.val;
    b_d.z    = sz.val;
    b_d.clip = clip_a_q | sx.clip | sy.clip | sz.clip;
  end

  assign out_valid_o = b_vld_q;
  assign out_data_o  = b_q;

endmodule

// ===== src/vsrt_rotate.sv =====
// Plane rotation of (x, y) by Q2.14 cos/sin; z rides along untouched.
`timescale 1ns / 1ps

module vsrt_rotate import vsrt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  vec_t        in_data_i,
  input  logic [31:0] coeffs_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output vec_t        out_data_o
);

  logic a_vld_q, b_vld_q;
  logic a_rdy, b_rdy;
  logic signed [ProdW-1:0] cx_q, sy_q, cy_q, sx_q;
  logic signed [CoordW-1:0] z_q;
  logic clip_a_q;
  logic signed [CoefW-1:0] cos_c, sin_c;
  logic signed [ProdW+1:0] nx, ny;
  sat_res_t rx, ry;
  vec_t b_d, b_q;

  assign cos_c = $signed(coeffs_i[31:16]);
  assign sin_c = $signed(coeffs_i[15:0]);

  assign b_rdy      = !b_vld_q || out_ready_i;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= in_valid_i;
      if (b_rdy) b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      cx_q     <= in_data_i.x * cos_c;
      sy_q     <= in_data_i.y * sin_c;
      cy_q     <= in_data_i.y * cos_c;
      sx_q     <= in_data_i.x * sin_c;
      z_q      <= in_data_i.z;
      clip_a_q <= in_data_i.clip;
    end
    if (b_rdy && a_vld_q) begin
      b_q <= b_d;
    end
  end

  // x' = c*x - s*y, y' = c*y + s*x, both from the old values; round off 14 bits.
  always_comb begin
    nx = $signed({{2{cx_q[ProdW-1]}}, cx_q} - {{2{sy_q[ProdW-1]}}, sy_q}
          + (ProdW+2)'(8192)) >>> 14;
    ny = $signed({{2{cy_q[ProdW-1]}}, cy_q} + {{2{sx_q[ProdW-1]}}, sx_q}
          + (ProdW+2)'(8192)) >>> 14;
    rx = sat32(nx[SatW-1:0]);
    ry = sat32(ny[SatW-1:0]);
    b_d.x    = rx.val;
    b_d.y    = ry.val;
    b_d.z    = z_q;
    b_d.clip = clip_a_q | rx.clip | ry.clip;
  end

  assign out_valid_o = b_vld_q;
  assign out_data_o  = b_q;

endmodule

// ===== src/vsrt_translate.sv =====
// Per-axis offset add with saturation into the output register.
`timescale 1ns / 1ps

module vsrt_translate import vsrt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  vec_t                     in_data_i,
  input  logic signed [CoordW-1:0] tx_i,
  input  logic signed [CoordW-1:0] ty_i,
  input  logic signed [CoordW-1:0] tz_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output vec_t                     out_data_o
);

  logic vld_q, rdy;
  vec_t d, q;
  sat_res_t sx, sy, sz;

  assign rdy        = !vld_q || out_ready_i;
  assign in_ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) q <= d;
  end

  always_comb begin
    sx = sat32(SatW'(in_data_i.x) + SatW'(tx_i));
    sy = sat32(SatW'(in_data_i.y) + SatW'(ty_i));
    sz = sat32(SatW'(in_data_i.z) + SatW'(tz_i));
    d.x    = sx.val;
    d.y    = sy.val;
    d.z    = sz.val;
    d.clip = in_data_i.clip | sx.clip | sy.clip | sz.clip;
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = q;

endmodule

// ===== test/tb_vertex_scale_rotate_translate.sv =====
// Self-checking testbench for the vertex scale, rotate and translate pipeline.
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
} vertex_t;

class vertex_scoreboard;
  logic [vsrt_pkg::CfgDataW-1:0] scale_factors;
  logic [31:0]                   rot_coeffs[3];
  logic [31:0]                   offsets[3];
  vsrt_pkg::vec_t                pending_results[$];
  bit                            clipped;
  int unsigned                   mismatches;
  int unsigned                   vertices_seen;
  int unsigned                   results_seen;
  int unsigned                   clipped_results;

  function new();
    scale_factors = vsrt_pkg::ScaleReset;
    foreach (rot_coeffs[i]) rot_coeffs[i] = vsrt_pkg::RotReset;
    foreach (offsets[i]) offsets[i] = '0;
  endfunction

  function void write_register(input logic [vsrt_pkg::CfgIdxW-1:0] idx,
                               input logic [vsrt_pkg::CfgDataW-1:0] data);
    case (idx)
      vsrt_pkg::RegScale:  scale_factors = data;
      vsrt_pkg::RegRotX:   rot_coeffs[0] = data[31:0];
      vsrt_pkg::RegRotY:   rot_coeffs[1] = data[31:0];
      vsrt_pkg::RegRotZ:   rot_coeffs[2] = data[31:0];
      vsrt_pkg::RegTransX: offsets[0] = data[31:0];
      vsrt_pkg::RegTransY: offsets[1] = data[31:0];
      vsrt_pkg::RegTransZ: offsets[2] = data[31:0];
      default: ;
    endcase
  endfunction

  // Add half an LSB of the result, then floor.
  function longint round_off(input longint v, input int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function longint clamp(input longint v);
    if (v > longint'(vsrt_pkg::SatMax)) begin
      clipped = 1'b1;
      return longint'(vsrt_pkg::SatMax);
    end
    if (v < longint'(vsrt_pkg::SatMin)) begin
      clipped = 1'b1;
      return longint'(vsrt_pkg::SatMin);
    end
    return v;
  endfunction

  // Both new coordinates come from the old pair.
  function void rotate(inout longint a, inout longint b, input logic [31:0] cs,
                       input bit plus);
    longint c, s, na, nb;
    c = longint'($signed(cs[31:16]));
    s = longint'($signed(cs[15:0]));
    if (plus) begin
      na = c * a + s * b;
      nb = c * b - s * a;
    end else begin
      na = c * a - s * b;
      nb = c * b + s * a;
    end
    a = clamp(round_off(na, 14));
    b = clamp(round_off(nb, 14));
  endfunction

  function vsrt_pkg::vec_t transform(input vertex_t v);
    longint x, y, z;
    vsrt_pkg::vec_t r;
    clipped = 1'b0;
    x = clamp(round_off(longint'(v.x) * longint'($signed(scale_factors[47:32])), 12));
    y = clamp(round_off(longint'(v.y) * longint'($signed(scale_factors[31:16])), 12));
    z = clamp(round_off(longint'(v.z) * longint'($signed(scale_factors[15:0])), 12));
    rotate(y, z, rot_coeffs[0], 1'b0);
    rotate(x, z, rot_coeffs[1], 1'b1);
    rotate(x, y, rot_coeffs[2], 1'b0);
    x = clamp(x + longint'($signed(offsets[0])));
    y = clamp(y + longint'($signed(offsets[1])));
    z = clamp(z + longint'($signed(offsets[2])));
    r.x    = x[31:0];
    r.y    = y[31:0];
    r.z    = z[31:0];
    r.clip = clipped;
    return r;
  endfunction

  function void note_vertex(input vertex_t v);
    pending_results.insert(pending_results.size(), transform(v));
    vertices_seen++;
  endfunction

  function int unsigned outstanding();
    return pending_results.size();
  endfunction

  function void check_result(input vsrt_pkg::vec_t got);
    vsrt_pkg::vec_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("result with no vertex outstanding: x=%0d y=%0d z=%0d saturated=%0b",
             got.x, got.y, got.z, got.clip);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (want.clip) clipped_results++;
    if (got.x !== want.x) begin
      $error("out_x: expected %0d, got %0d", want.x, got.x);
      mismatches++;
    end
    if (got.y !== want.y) begin
      $error("out_y: expected %0d, got %0d", want.y, got.y);
      mismatches++;
    end
    if (got.z !== want.z) begin
      $error("out_z: expected %0d, got %0d", want.z, got.z);
      mismatches++;
    end
    if (got.clip !== want.clip) begin
      $error("saturated: expected %0b, got %0b", want.clip, got.clip);
      mismatches++;
    end
  endfunction
endclass

module tb_vertex_scale_rotate_translate;
  import vsrt_pkg::*;

  localparam int unsigned ClkPeriod    = 10;
  // Index with no register behind it; the block must drop writes there.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned RandomItems  = 94;
  localparam int unsigned SettleCycles = PipeDepth + 4;
  // Generous limit on the length of the whole run.
  localparam longint unsigned TimeoutNs = 2_000_000;

  localparam logic [31:0] CoordMax = 32'h7FFF_FFFF;
  localparam logic [31:0] CoordMin = 32'h8000_0000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  vsrt_in_if  vtx_if ();
  vsrt_out_if res_if ();

  vertex_scoreboard board;
  int unsigned      src_idle_pct;
  int unsigned      sink_stall_pct;
  int unsigned      cfg_writes;
  int unsigned      settings_used;

  vertex_scale_rotate_translate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .vtx_i       (vtx_if),
    .res_o       (res_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Hard stop in case the pipeline hangs or drops results.
  initial begin : watchdog
    #(TimeoutNs);
    $display("timeout: %0d results still outstanding", board.outstanding());
    $display("** vertex_scale_rotate_translate: FAILED **");
    $finish;
  end

  // Randomly stall the result side; stall rate follows the current phase.
  initial res_if.ready = 1'b0;
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Check each result transaction against the oldest prediction.
  always @(posedge clk_i) begin : watch_results
    vec_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.x    = res_if.out_x;
      got.y    = res_if.out_y;
      got.z    = res_if.out_z;
      got.clip = res_if.saturated;
      board.check_result(got);
    end
  end

  // Drive one register write; the caller drops the write enable afterwards.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    board.write_register(idx, data);
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // Offer one vertex, after a random gap, and hold it until accepted.
  // Valid is left high so back-to-back vertices are offered without a gap.
  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      vtx_if.valid = 1'b0;
      @(negedge clk_i);
    end
    vtx_if.vertex_x = v.x;
    vtx_if.vertex_y = v.y;
    vtx_if.vertex_z = v.z;
    vtx_if.valid    = 1'b1;
    do @(posedge clk_i); while (!vtx_if.ready);
    board.note_vertex(v);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline go quiet.
  task automatic settle_pipeline();
    vtx_if.valid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Styles: 0 mixes typical and extreme values, 1 all maximum, 2 all minimum.
  function automatic logic [15:0] pick_scale(input int style);
    if (style == 1) return 16'h7FFF;
    if (style == 2) return 16'h8000;
    case ($urandom_range(0, 7))
      0: return 16'h1000;   // 1.0
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'h0000;
      4: return 16'hF000;   // -1.0
      5: return 16'h0800;   // 0.5, produces rounding ties
      6: return 16'($urandom);
      default: return 16'($urandom_range(0, 16'h4000) - 16'h2000);
    endcase
  endfunction

  function automatic logic [31:0] pick_rot(input int style);
    if (style == 1) return 32'h7FFF_7FFF;
    if (style == 2) return 32'h8000_8000;
    case ($urandom_range(0, 9))
      0: return RotReset;
      1: return {16'h0000, 16'h4000};   // 90 degrees
      2: return {16'hC000, 16'h0000};   // 180 degrees
      3: return {16'h0000, 16'hC000};   // 270 degrees
      4: return {16'h2D41, 16'h2D41};   // 45 degrees
      5: return {16'h376D, 16'h2000};   // 30 degrees
      6: return {16'h2D41, 16'hD2BF};   // -45 degrees
      7: return {16'h7FFF, 16'h8000};   // well beyond unit length
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_offset(input int style);
    if (style == 1) return CoordMax;
    if (style == 2) return CoordMin;
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return CoordMax;
      2: return CoordMin;
      3: return $urandom;
      default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  // Mostly small coordinates so that chains of stages stay in range,
  // plus full-range values and the extremes.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return CoordMax;
          1: return CoordMin;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          default: return 32'h1;
        endcase
      end
      1, 2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h007F_FFFF) - 32'h0040_0000;
    endcase
  endfunction

  // Load a full setting. Junk goes into the bits above each 32-bit register,
  // and the unused index is sometimes written to prove it is dropped.
  task automatic load_config(input int style);
    write_reg(RegScale, {pick_scale(style), pick_scale(style), pick_scale(style)});
    write_reg(RegRotX, {16'($urandom), pick_rot(style)});
    write_reg(RegRotY, {16'($urandom), pick_rot(style)});
    write_reg(RegRotZ, {16'($urandom), pick_rot(style)});
    write_reg(RegTransX, {16'($urandom), pick_offset(style)});
    write_reg(RegTransY, {16'($urandom), pick_offset(style)});
    write_reg(RegTransZ, {16'($urandom), pick_offset(style)});
    if ($urandom_range(0, 1) == 1) write_reg(RegUnused, {16'($urandom), 32'($urandom)});
    cfg_we_i = 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    board           = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    vtx_if.valid    = 1'b0;
    vtx_if.vertex_x = '0;
    vtx_if.vertex_y = '0;
    vtx_if.vertex_z = '0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    cfg_writes      = 0;
    settings_used   = 1;

    // Hold reset, then release it on a falling edge.
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset setting is the identity transform: field extremes pass through.
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(CoordMax, CoordMax, CoordMax);
    send_vertex(CoordMin, CoordMin, CoordMin);
    send_vertex(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
    send_vertex(CoordMax, CoordMin, 32'h0001_0000);
    send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    settle_pipeline();

    // Scale extremes: near +8 on x, -8 on y, and 0.5 on z so odd z values
    // hit rounding ties (those go toward plus infinity). Large inputs clip.
    write_reg(RegScale, {16'h7FFF, 16'h8000, 16'h0800});
    cfg_we_i = 1'b0;
    settings_used++;
    send_vertex(32'h3, 32'hFFFF_FFFD, 32'h1);
    send_vertex(32'h1, 32'h1, 32'hFFFF_FFFF);
    send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3);
    send_vertex(32'h0000_1000, 32'h0000_1000, 32'hFFFF_FFFD);
    send_vertex(CoordMax, CoordMax, CoordMax);
    send_vertex(CoordMin, CoordMin, CoordMin);
    settle_pipeline();

    // Halving on x rotation gives ties there; y and z coefficients are
    // beyond unit length; offsets at both extremes make translation clip.
    // The unused index gets all ones and must change nothing.
    write_reg(RegScale, ScaleReset);
    write_reg(RegRotX, {16'hFFFF, 16'h2000, 16'h0000});
    write_reg(RegRotY, {16'h0000, 16'h7FFF, 16'h8000});
    write_reg(RegRotZ, {16'h0000, 16'h8000, 16'h7FFF});
    write_reg(RegTransX, {16'h0000, CoordMax});
    write_reg(RegTransY, {16'hFFFF, CoordMin});
    write_reg(RegTransZ, {16'h0000, 32'h1});
    write_reg(RegUnused, '1);
    cfg_we_i = 1'b0;
    settings_used++;
    send_vertex(32'h1, 32'hFFFF_FFFF, 32'h3);
    send_vertex(CoordMax, CoordMin, CoordMax);
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000);
    send_vertex(CoordMin, CoordMax, CoordMin);
    settle_pipeline();

    // Random phases, each with a fresh setting and its own idle pattern:
    // none, sender idle half the time, receiver stalling half the time,
    // and both at 11 percent. The last two phases pin every register to
    // its maximum and then its minimum.
    for (int p = 0; p < RandomPhases; p++) begin
      load_config((p == 6) ? 1 : (p == 7) ? 2 : 0);
      case (p % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 50;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 50;
        end
        default: begin
          src_idle_pct   = 11;
          sink_stall_pct = 11;
        end
      endcase
      for (int n = 0; n < RandomItems; n++) begin
        // Once mid-phase, hold the sender until the pipeline fully drains.
        if (p == 5 && n == RandomItems / 2) settle_pipeline();
        send_vertex(pick_coord(), pick_coord(), pick_coord());
      end
      settle_pipeline();
    end

    $display("Run covered %0d vertices under %0d settings (%0d register writes);",
             board.vertices_seen, settings_used, cfg_writes);
    $display("%0d results checked, %0d of them saturated, %0d mismatches.",
             board.results_seen, board.clipped_results, board.mismatches);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("** vertex_scale_rotate_translate: PASSED **");
    end else begin
      $display("** vertex_scale_rotate_translate: FAILED **");
    end
    $finish;
  end

endmodule
